// ===== rtl/hta_pkg.sv =====
// hta_pkg: shared sizes, codes and struct types for the handle table allocator
// used by hta_ctrl, hta_datapath and handle_table_allocator_core; no dependencies

package hta_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // request kinds
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_ARG    = 2'd1;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] handle_in;
    logic [31:0] object_value;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  status;
    logic [5:0]  handle_out;
    logic [31:0] object_out;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the incoming request
    logic exec;        // evaluate the request and update the table
    logic finish_get;  // post a get result from the read data
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic get_hit;     // held request is a get naming an occupied slot
  } stat_t;

endpackage

// ===== rtl/hta_ctrl.sv =====
// hta_ctrl: request sequencer for the handle table allocator
// depends on hta_pkg (ctrl_t, stat_t)

module hta_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  hta_pkg::stat_t stat,
  output hta_pkg::ctrl_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd.load       = 1'b0;
    cmd.exec       = 1'b0;
    cmd.finish_get = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.get_hit ? S_READ : S_IDLE;
      end
      S_READ: begin
        cmd.finish_get = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_EXEC))
    else $error("request capture not followed by execute");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_IDLE))
    else $error("read state held longer than one cycle");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.finish_get}))
    else $error("more than one datapath command at once");

endmodule

// ===== rtl/hta_datapath.sv =====
// hta_datapath: request register, slot memory, occupancy bits, free-slot finder
// and result register; depends on hta_pkg

module hta_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  hta_pkg::ctrl_t cmd,
  output hta_pkg::stat_t stat,
  input  hta_pkg::req_t  req,
  output logic           out_valid,
  output hta_pkg::res_t  res
);

  typedef logic [hta_pkg::VALUE_WIDTH-1:0] value_t;
  typedef logic [hta_pkg::IDX_W-1:0]       idx_t;

  // request held for the duration of one item
  hta_pkg::req_t req_r;

  // slot storage; occupancy lives in flops, reset clears it
  value_t                          mem [hta_pkg::SLOT_COUNT];
  logic [hta_pkg::SLOT_COUNT-1:0]  valid_r;
  value_t                          rdata_r;

  logic           out_valid_r;
  hta_pkg::res_t  res_r;

  value_t obj;
  idx_t   idx;
  logic   in_range;
  logic   hit;
  logic   free_found;
  idx_t   free_idx;

  logic           post;
  hta_pkg::res_t  post_res;
  logic           do_write;
  logic           do_clear;
  logic           do_read;

  assign obj      = value_t'(req_r.object_value);
  assign idx      = req_r.handle_in[hta_pkg::IDX_W-1:0];
  assign in_range = ({16'd0, req_r.handle_in} < 32'(hta_pkg::SLOT_COUNT));
  assign hit      = in_range && valid_r[idx];

  // lowest clear occupancy bit
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = hta_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = idx_t'(i);
      end
    end
  end

  assign stat.get_hit = (req_r.op == hta_pkg::OP_GET) && hit;

  always_comb begin
    post                = 1'b0;
    post_res            = '0;
    do_write            = 1'b0;
    do_clear            = 1'b0;
    do_read             = 1'b0;
    post_res.status     = hta_pkg::ST_BAD_ARG;
    if (cmd.exec) begin
      post = 1'b1;
      unique case (req_r.op)
        hta_pkg::OP_CREATE: begin
          if (obj == '0) begin
            post_res.status = hta_pkg::ST_BAD_ARG;
          end else if (!free_found) begin
            post_res.status = hta_pkg::ST_FULL;
          end else begin
            post_res.status     = hta_pkg::ST_OK;
            post_res.handle_out = 6'(free_idx);
            do_write            = 1'b1;
          end
        end
        hta_pkg::OP_FREE: begin
          if (!hit) begin
            post_res.status = hta_pkg::ST_BAD_HANDLE;
          end else begin
            post_res.status = hta_pkg::ST_OK;
            do_clear        = 1'b1;
          end
        end
        hta_pkg::OP_GET: begin
          if (!hit) begin
            post_res.status = hta_pkg::ST_BAD_HANDLE;
          end else begin
            post    = 1'b0;
            do_read = 1'b1;
          end
        end
        default: begin
          post_res.status = hta_pkg::ST_BAD_ARG;
        end
      endcase
    end else if (cmd.finish_get) begin
      post                = 1'b1;
      post_res.status     = hta_pkg::ST_OK;
      post_res.object_out = 32'(rdata_r);
    end
    post_res.ok = (post_res.status == hta_pkg::ST_OK);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[free_idx] <= obj;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      rdata_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_write) begin
        valid_r[free_idx] <= 1'b1;
      end
      if (do_clear) begin
        valid_r[idx] <= 1'b0;
      end
      out_valid_r <= post;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      res_r <= post_res;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.ok == (res_r.status == hta_pkg::ST_OK)))
    else $error("ok flag disagrees with status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.status != hta_pkg::ST_OK))
      |-> (res_r.handle_out == '0 && res_r.object_out == '0))
    else $error("refused request carries nonzero payload");

  a_create_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> ($countones(valid_r) == $past($countones(valid_r)) + 1))
    else $error("successful create did not occupy exactly one slot");

endmodule

// ===== rtl/handle_table_allocator_core.sv =====
// handle_table_allocator_core: top level of the handle table allocator
// depends on hta_pkg, hta_ctrl and hta_datapath
//
// usage:
// - a request transfer happens at a rising edge with start high and busy low;
//   in_req carries op (create, free, get), handle_in and object_value
// - each request gives exactly one result: out_valid is high for one cycle
//   and out_res holds ok, status, handle_out and object_out in that cycle
// - create and free: the result register is loaded from the execute state;
//   get naming an occupied slot passes through an extra read state, which
//   takes the registered read of the slot memory
// - busy is high while a request is in flight, so one request is worked on
//   at a time; a new request can be taken in the cycle its predecessor's
//   result is on the output
// - the free-slot search is a priority encoder over the occupancy flops,
//   done in the execute cycle
// - reset (synchronous, active low) clears all occupancy flops, so every
//   slot reads as free at once; no clearing pass is needed
// - the receiver cannot stall: each result is taken in its strobe cycle

module handle_table_allocator_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hta_pkg::req_t in_req,
  output logic          out_valid,
  output hta_pkg::res_t out_res
);

  // command and status between sequencer and datapath
  hta_pkg::ctrl_t cmd;
  hta_pkg::stat_t stat;

  hta_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  hta_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .req       (in_req),
    .out_valid (out_valid),
    .res       (out_res)
  );

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for handle_table_allocator_core, with its own slot table
// predictor, a directed table of requests, then random bursts of fill, drain, mix and noise
// depends on hta_pkg and handle_table_allocator_core

module testbench;

  // op code that the block does not define, refused as a bad argument
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1700;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX, BURST_NOISE} burst_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    hta_pkg::req_t req;
    bit            typed;
    hta_pkg::res_t want;
  } stim_row_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  hta_pkg::req_t in_req;
  logic          out_valid;
  hta_pkg::res_t out_res;

  // predictor state: one value per slot, zero means free
  logic [hta_pkg::VALUE_WIDTH-1:0] slot_mem [hta_pkg::SLOT_COUNT];

  hta_pkg::res_t pending_res [$];
  stim_row_t     directed_rows [$];
  int            fail_cnt = 0;
  int            checked_cnt = 0;
  int            req_cnt = 0;
  int            status_cnt [4] = '{0, 0, 0, 0};
  int            burst_cnt [4] = '{0, 0, 0, 0};

  handle_table_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: applies one request to the shadow table and returns its result
  // ---------------------------------------------------------------------------
  function automatic hta_pkg::res_t table_step(input hta_pkg::req_t r);
    hta_pkg::res_t                   res;
    logic [hta_pkg::VALUE_WIDTH-1:0] val;
    logic [63:0]                     wide;
    bit                              placed;
    bit                              live;
    res = '0;
    res.status = hta_pkg::ST_BAD_ARG;
    val = r.object_value;
    placed = 1'b0;
    // a handle is usable only when in range and its slot is occupied
    live = (r.handle_in < hta_pkg::SLOT_COUNT) && (slot_mem[r.handle_in] != '0);
    case (r.op)
      hta_pkg::OP_CREATE: begin
        if (val != '0) begin
          res.status = hta_pkg::ST_FULL;
          // lowest free slot wins
          for (int i = 0; i < hta_pkg::SLOT_COUNT; i++) begin
            if (!placed && slot_mem[i] == '0) begin
              slot_mem[i] = val;
              res.status = hta_pkg::ST_OK;
              res.handle_out = 6'(i);
              placed = 1'b1;
            end
          end
        end
      end
      hta_pkg::OP_FREE: begin
        if (live) begin
          slot_mem[r.handle_in] = '0;
          res.status = hta_pkg::ST_OK;
        end else begin
          res.status = hta_pkg::ST_BAD_HANDLE;
        end
      end
      hta_pkg::OP_GET: begin
        if (live) begin
          wide = 64'(slot_mem[r.handle_in]);
          res.status = hta_pkg::ST_OK;
          res.object_out = wide[31:0];
        end else begin
          res.status = hta_pkg::ST_BAD_HANDLE;
        end
      end
      default: res.status = hta_pkg::ST_BAD_ARG;
    endcase
    res.ok = (res.status == hta_pkg::ST_OK);
    return res;
  endfunction

  function automatic stim_row_t mk_row(input logic [1:0] op, input logic [15:0] h,
                                       input logic [31:0] v, input bit typed,
                                       input logic [1:0] st, input logic [5:0] ho,
                                       input logic [31:0] oo);
    stim_row_t row;
    row.req.op = op;
    row.req.handle_in = h;
    row.req.object_value = v;
    row.typed = typed;
    row.want.ok = (st == hta_pkg::ST_OK);
    row.want.status = st;
    row.want.handle_out = ho;
    row.want.object_out = oo;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // random field generators
  // ---------------------------------------------------------------------------

  // mostly back to back, often short gaps, a few long ones
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // live_pct of the time an occupied slot if there is one, else a stray handle
  function automatic logic [15:0] pick_handle(input int live_pct);
    int s;
    s = $urandom_range(0, hta_pkg::SLOT_COUNT - 1);
    if ($urandom_range(0, 99) < live_pct) begin
      for (int k = 0; k < hta_pkg::SLOT_COUNT; k++) begin
        if (slot_mem[(s + k) % hta_pkg::SLOT_COUNT] != '0)
          return 16'((s + k) % hta_pkg::SLOT_COUNT);
      end
    end
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'(hta_pkg::SLOT_COUNT + $urandom_range(0, 3));
      default: return 16'(s);
    endcase
  endfunction

  function automatic logic [31:0] obj_value(input int zero_pct);
    int p;
    p = $urandom_range(0, 99);
    if (p < zero_pct) return '0;
    if (p < zero_pct + 5) return '1;
    if (p < zero_pct + 10) return 32'(1) << $urandom_range(0, 31);
    return $urandom;
  endfunction

  function automatic hta_pkg::req_t gen_req(input burst_t mode);
    hta_pkg::req_t r;
    int            p;
    p = $urandom_range(0, 99);
    r.handle_in = 16'($urandom);
    r.object_value = $urandom;
    case (mode)
      BURST_FILL: begin
        if (p < 90) begin
          r.op = hta_pkg::OP_CREATE;
          r.object_value = obj_value(0);
          if (r.object_value == '0) r.object_value = 32'h1;
        end else begin
          r.op = hta_pkg::OP_GET;
          r.handle_in = pick_handle(90);
        end
      end
      BURST_DRAIN: begin
        if (p < 50) begin
          r.op = hta_pkg::OP_FREE;
          r.handle_in = pick_handle(90);
        end else if (p < 80) begin
          r.op = hta_pkg::OP_GET;
          r.handle_in = pick_handle(85);
        end else begin
          r.op = hta_pkg::OP_CREATE;
          r.object_value = obj_value(5);
        end
      end
      BURST_MIX: begin
        if (p < 35) begin
          r.op = hta_pkg::OP_CREATE;
          r.object_value = obj_value(5);
        end else begin
          r.op = (p < 65) ? hta_pkg::OP_FREE : hta_pkg::OP_GET;
          r.handle_in = pick_handle(75);
        end
      end
      default: begin
        // noise: any op code, any handle, zero values now and then
        r.op = 2'($urandom_range(0, 3));
        r.object_value = obj_value(20);
        if ($urandom_range(0, 1) == 0) r.handle_in = pick_handle(50);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one request transfer; start stays high across back-to-back items,
  // it is only lowered when a gap or a drain pause comes first
  // ---------------------------------------------------------------------------
  task automatic issue(input hta_pkg::req_t r, input bit typed, input hta_pkg::res_t want,
                       input int gap, input bit drain);
    hta_pkg::res_t pred;
    if (drain || gap > 0) begin
      start <= 1'b0;
      // hold off until every outstanding result is back
      if (drain) begin
        do @(posedge clk); while (pending_res.size() != 0);
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer happened at this edge; the predictor runs on every row so
    // its table stays in step even where the expectation is typed in
    pred = table_step(r);
    pending_res.push_back(typed ? want : pred);
    status_cnt[pred.status]++;
    req_cnt++;
  endtask

  task automatic log_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // checker: every strobed result is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hta_pkg::res_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_res.size() == 0) begin
        log_fail($sformatf("result with nothing pending: ok=%0d st=%0d h=%0d obj=%h",
                           out_res.ok, out_res.status, out_res.handle_out,
                           out_res.object_out));
      end else begin
        want = pending_res.pop_front();
        checked_cnt++;
        if (out_res.ok !== want.ok || out_res.status !== want.status ||
            out_res.handle_out !== want.handle_out ||
            out_res.object_out !== want.object_out) begin
          log_fail($sformatf({"exp ok=%0d st=%0d h=%0d obj=%h, ",
                              "got ok=%0d st=%0d h=%0d obj=%h"},
                             want.ok, want.status, want.handle_out, want.object_out,
                             out_res.ok, out_res.status, out_res.handle_out,
                             out_res.object_out));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    burst_t        mode;
    int            len;
    int            done;
    bit            no_idle;
    bit            hold;
    hta_pkg::res_t none;

    none = '0;
    for (int i = 0; i < hta_pkg::SLOT_COUNT; i++) slot_mem[i] = '0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req <= '0;

    // directed rows: empty table, zero object, unused op, extreme values and
    // handles, double free and lowest-free reuse
    directed_rows.push_back(mk_row(hta_pkg::OP_GET, 16'h0000, 32'h0, 1'b1,
                                   hta_pkg::ST_BAD_HANDLE, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_FREE, 16'h0000, 32'h0, 1'b1,
                                   hta_pkg::ST_BAD_HANDLE, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_CREATE, 16'h0000, 32'h0, 1'b1,
                                   hta_pkg::ST_BAD_ARG, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(OP_UNUSED, 16'h0000, 32'h0, 1'b1,
                                   hta_pkg::ST_BAD_ARG, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_CREATE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                                   hta_pkg::ST_OK, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_CREATE, 16'h0000, 32'h0000_0001, 1'b1,
                                   hta_pkg::ST_OK, 6'd1, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_GET, 16'h0000, 32'h0, 1'b1,
                                   hta_pkg::ST_OK, 6'd0, 32'hFFFF_FFFF));
    directed_rows.push_back(mk_row(hta_pkg::OP_GET, 16'h0001, 32'hFFFF_FFFF, 1'b1,
                                   hta_pkg::ST_OK, 6'd0, 32'h1));
    directed_rows.push_back(mk_row(hta_pkg::OP_GET, 16'hFFFF, 32'h0, 1'b1,
                                   hta_pkg::ST_BAD_HANDLE, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_GET, 16'(hta_pkg::SLOT_COUNT), 32'h0, 1'b1,
                                   hta_pkg::ST_BAD_HANDLE, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_FREE, 16'(hta_pkg::SLOT_COUNT - 1), 32'h0,
                                   1'b1, hta_pkg::ST_BAD_HANDLE, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_FREE, 16'h0000, 32'h0, 1'b1,
                                   hta_pkg::ST_OK, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_GET, 16'h0000, 32'h0, 1'b1,
                                   hta_pkg::ST_BAD_HANDLE, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_FREE, 16'h0000, 32'h0, 1'b1,
                                   hta_pkg::ST_BAD_HANDLE, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_CREATE, 16'hFFFF, 32'h8000_0000, 1'b1,
                                   hta_pkg::ST_OK, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                                   hta_pkg::ST_BAD_ARG, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_CREATE, 16'h5555, 32'h0001_0000, 1'b0,
                                   hta_pkg::ST_OK, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_GET, 16'h0002, 32'h0, 1'b0,
                                   hta_pkg::ST_OK, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_FREE, 16'h0001, 32'h0, 1'b0,
                                   hta_pkg::ST_OK, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_CREATE, 16'hAAAA, 32'h5A5A_A5A5, 1'b0,
                                   hta_pkg::ST_OK, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_GET, 16'h0001, 32'h0, 1'b0,
                                   hta_pkg::ST_OK, 6'd0, 32'd0));
    directed_rows.push_back(mk_row(hta_pkg::OP_FREE, 16'h8000, 32'h0, 1'b1,
                                   hta_pkg::ST_BAD_HANDLE, 6'd0, 32'd0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want,
            idle_len(), 1'b0);

    // random bursts; the first one fills the table past full and is followed
    // by a pause that lets every outstanding result come back
    done = 0;
    hold = 1'b0;
    while (done < RANDOM_ITEMS) begin
      if (done == 0) begin
        mode = BURST_FILL;
        len = hta_pkg::SLOT_COUNT + 16;
      end else begin
        mode = burst_t'($urandom_range(0, 3));
        len = $urandom_range(15, 80);
      end
      burst_cnt[mode]++;
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len && done < RANDOM_ITEMS; k++) begin
        issue(gen_req(mode), 1'b0, none, no_idle ? 0 : idle_len(), hold);
        hold = 1'b0;
        done++;
      end
      hold = (done == len) || ($urandom_range(0, 3) == 0);
    end

    // drain and let the pipeline settle so stray strobes get caught
    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests: %0d ok, %0d bad argument, %0d bad handle, %0d full",
             req_cnt, status_cnt[hta_pkg::ST_OK], status_cnt[hta_pkg::ST_BAD_ARG],
             status_cnt[hta_pkg::ST_BAD_HANDLE], status_cnt[hta_pkg::ST_FULL]);
    $display("bursts fill/drain/mix/noise: %0d/%0d/%0d/%0d, %0d results compared, %0d errors",
             burst_cnt[BURST_FILL], burst_cnt[BURST_DRAIN], burst_cnt[BURST_MIX],
             burst_cnt[BURST_NOISE], checked_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(12 * 400000);
    $display("timeout with %0d results outstanding", pending_res.size());
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hta_pkg.sv
rtl/hta_ctrl.sv
rtl/hta_datapath.sv
rtl/handle_table_allocator_core.sv
tb/testbench.sv
